// ===== rtl/pfla_pkg.sv =====
`default_nettype none

package pfla_pkg;

   localparam int ADDR_W = 40;
   localparam int BASE_W = ADDR_W + 1;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   localparam logic CSR_REGION_START = 1'b0;
   localparam logic CSR_REGION_STOP  = 1'b1;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_INIT,
      CMD_ALLOC,
      CMD_FREE,
      CMD_BAD
   } cmd_op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_BASE,
      F_CLASS
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_EXEC,
      B_FILL,
      B_POP
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/page_free_list_allocator.sv =====
// Channel    Ports                                           Handshake
// request    req_mode, req_page_address                      start high, busy low
// response   rsp_granted_address, rsp_status                 rsp_valid, one cycle
// csr        csr_index, csr_write_data                       csr_write_enable
//
// A free, a bad free or an unused mode passes F_BASE, F_CLASS, the queue, B_IDLE
// and B_EXEC; an allocation also B_POP (the link memory read is registered), and
// an init with pages B_FILL, since the back end writes one link entry per cycle.
// Busy stays high from acceptance until the cycle in which rsp_valid shows.
// Reset empties the free list; link entries are only read after being written.
// The receiver cannot stall, so results never wait.
`default_nettype none

module page_free_list_allocator #(
   parameter int PAGE_SHIFT = 12,
   parameter int MAX_PAGES  = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [pfla_pkg::ADDR_W-1:0]  req_page_address,
   output logic                              rsp_valid,
   output logic [pfla_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [1:0]                        rsp_status,
   input  wire logic                         csr_write_enable,
   input  wire logic                         csr_index,
   input  wire logic [pfla_pkg::ADDR_W-1:0]  csr_write_data
);
   import pfla_pkg::*;

   localparam int IDX_W = $clog2(MAX_PAGES + 1);
   localparam int OP_W  = $bits(cmd_op_type);
   localparam int CMD_W = OP_W + IDX_W + BASE_W;

   logic [ADDR_W-1:0] region_start_ff, region_start_in;
   logic [ADDR_W-1:0] region_stop_ff, region_stop_in;

   logic              accept;
   logic              front_busy;
   logic              back_busy;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic              q_full;
   cmd_op_type        front_op;
   logic [IDX_W-1:0]  front_arg;
   logic [BASE_W-1:0] front_base;
   logic [CMD_W-1:0]  q_rd_data;
   cmd_op_type        back_op;

   always_comb begin
      region_start_in = region_start_ff;
      region_stop_in  = region_stop_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_REGION_START: region_start_in = csr_write_data;
            CSR_REGION_STOP:  region_stop_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_stop_ff  <= '0;
      end else begin
         region_start_ff <= region_start_in;
         region_stop_ff  <= region_stop_in;
      end
   end

   assign busy   = front_busy || !q_empty || back_busy;
   assign accept = start && !busy;

   pfla_front #(
      .PAGE_SHIFT (PAGE_SHIFT),
      .MAX_PAGES  (MAX_PAGES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_mode         (req_mode),
      .req_page_address (req_page_address),
      .region_start     (region_start_ff),
      .region_stop      (region_stop_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .cmd_op           (front_op),
      .cmd_arg          (front_arg),
      .cmd_base         (front_base),
      .front_busy       (front_busy)
   );

   pfla_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_op, front_arg, front_base}),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign back_op = cmd_op_type'(q_rd_data[CMD_W-1 -: OP_W]);

   pfla_back #(
      .PAGE_SHIFT (PAGE_SHIFT),
      .MAX_PAGES  (MAX_PAGES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .cmd_op              (back_op),
      .cmd_arg             (q_rd_data[BASE_W +: IDX_W]),
      .cmd_base            (q_rd_data[BASE_W-1:0]),
      .back_busy           (back_busy),
      .rsp_valid           (rsp_valid),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/pfla_front.sv =====
`default_nettype none

module pfla_front #(
   parameter int PAGE_SHIFT = 12,
   parameter int MAX_PAGES  = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic [1:0]                            req_mode,
   input  wire logic [pfla_pkg::ADDR_W-1:0]           req_page_address,
   input  wire logic [pfla_pkg::ADDR_W-1:0]           region_start,
   input  wire logic [pfla_pkg::ADDR_W-1:0]           region_stop,
   input  wire logic                                  q_full,
   output logic                                       q_push,
   output pfla_pkg::cmd_op_type                       cmd_op,
   output logic [$clog2(MAX_PAGES + 1)-1:0]           cmd_arg,
   output logic [pfla_pkg::BASE_W-1:0]                cmd_base,
   output logic                                       front_busy
);
   import pfla_pkg::*;

   localparam int IDX_W = $clog2(MAX_PAGES + 1);
   localparam logic [BASE_W-1:0] PAGE_MASK = BASE_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [BASE_W-1:0] MAX_WIDE  = BASE_W'(MAX_PAGES);

   front_state_type     state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [BASE_W-1:0]   stop_wide;
   logic [BASE_W-1:0]   addr_wide;
   logic [BASE_W-1:0]   pages;
   logic [BASE_W-1:0]   offset;
   logic                bad_free;

   assign stop_wide = {1'b0, region_stop};
   assign addr_wide = {1'b0, addr_ff};
   assign pages     = (stop_wide - base_ff) >> PAGE_SHIFT;
   assign offset    = (addr_wide - base_ff) >> PAGE_SHIFT;
   assign bad_free  = ((addr_ff & PAGE_MASK[ADDR_W-1:0]) != '0) || (addr_ff < region_start)
                      || (addr_ff >= region_stop) || (addr_wide < base_ff)
                      || (offset >= MAX_WIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
      addr_ff <= addr_in;
      base_ff <= base_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      addr_in  = addr_ff;
      base_in  = base_ff;
      q_push   = 1'b0;
      cmd_op   = CMD_NOP;
      cmd_arg  = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               addr_in  = req_page_address;
               state_in = F_BASE;
            end
         end
         F_BASE: begin
            base_in  = ({1'b0, region_start} + PAGE_MASK) & ~PAGE_MASK;
            state_in = F_CLASS;
         end
         F_CLASS: begin
            case (mode_ff)
               MODE_INIT: begin
                  cmd_op = CMD_INIT;
                  if (stop_wide >= base_ff) begin
                     cmd_arg = (pages > MAX_WIDE) ? IDX_W'(MAX_PAGES) : pages[IDX_W-1:0];
                  end
               end
               MODE_ALLOC: begin
                  cmd_op = CMD_ALLOC;
               end
               MODE_FREE: begin
                  cmd_op  = bad_free ? CMD_BAD : CMD_FREE;
                  cmd_arg = offset[IDX_W-1:0];
               end
               default: begin
                  cmd_op = CMD_NOP;
               end
            endcase
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign cmd_base   = base_ff;
   assign front_busy = (state_ff != F_IDLE);

endmodule

`default_nettype wire

// ===== rtl/pfla_queue.sv =====
`default_nettype none

module pfla_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty,
   output logic                   full
);
   import pfla_pkg::*;

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/pfla_back.sv =====
`default_nettype none

module pfla_back #(
   parameter int PAGE_SHIFT = 12,
   parameter int MAX_PAGES  = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_empty,
   output logic                                       q_pop,
   input  wire pfla_pkg::cmd_op_type                  cmd_op,
   input  wire logic [$clog2(MAX_PAGES + 1)-1:0]      cmd_arg,
   input  wire logic [pfla_pkg::BASE_W-1:0]           cmd_base,
   output logic                                       back_busy,
   output logic                                       rsp_valid,
   output logic [pfla_pkg::ADDR_W-1:0]                rsp_granted_address,
   output logic [1:0]                                 rsp_status
);
   import pfla_pkg::*;

   localparam int IDX_W = $clog2(MAX_PAGES + 1);
   localparam int AW    = $clog2(MAX_PAGES);
   localparam logic [IDX_W-1:0] NULL_INDEX = IDX_W'(MAX_PAGES);

   back_state_type     state_ff, state_in;
   cmd_op_type         op_ff, op_in;
   logic [IDX_W-1:0]   arg_ff, arg_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [ADDR_W-1:0]  grant_ff, grant_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   fill_next;

   logic [IDX_W-1:0]   link_mem [MAX_PAGES];
   logic [IDX_W-1:0]   rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [IDX_W-1:0]   mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   assign fill_next = IDX_W'(fill_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= link_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         top_ff       <= NULL_INDEX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      arg_ff        <= arg_in;
      base_ff       <= base_in;
      fill_ff       <= fill_in;
      grant_ff      <= grant_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      arg_in        = arg_ff;
      base_in       = base_ff;
      top_in        = top_ff;
      fill_in       = fill_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = fill_ff[AW-1:0];
      mem_wdata     = top_ff;
      mem_re        = 1'b0;
      mem_raddr     = top_ff[AW-1:0];
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               op_in    = cmd_op;
               arg_in   = cmd_arg;
               base_in  = cmd_base;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_OK;
            case (op_ff)
               CMD_INIT: begin
                  top_in  = NULL_INDEX;
                  fill_in = '0;
                  if (arg_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = B_IDLE;
                  end else begin
                     state_in = B_FILL;
                  end
               end
               CMD_ALLOC: begin
                  if (top_ff == NULL_INDEX) begin
                     rsp_status_in = STATUS_EMPTY;
                     rsp_valid_in  = 1'b1;
                     state_in      = B_IDLE;
                  end else begin
                     mem_re   = 1'b1;
                     grant_in = ADDR_W'(base_ff + (BASE_W'(top_ff) << PAGE_SHIFT));
                     state_in = B_POP;
                  end
               end
               CMD_FREE: begin
                  mem_we       = 1'b1;
                  mem_waddr    = arg_ff[AW-1:0];
                  top_in       = arg_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = B_IDLE;
               end
               CMD_BAD: begin
                  rsp_status_in = STATUS_BAD;
                  rsp_valid_in  = 1'b1;
                  state_in      = B_IDLE;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = B_IDLE;
               end
            endcase
         end
         B_FILL: begin
            mem_we  = 1'b1;
            top_in  = fill_ff;
            fill_in = fill_next;
            if (fill_next == arg_ff) begin
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = B_IDLE;
            end
         end
         B_POP: begin
            top_in        = (rd_ff > NULL_INDEX) ? NULL_INDEX : rd_ff;
            rsp_addr_in   = grant_ff;
            rsp_status_in = STATUS_OK;
            rsp_valid_in  = 1'b1;
            state_in      = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign back_busy           = (state_ff != B_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/pfla_checker.sv =====
`default_nettype none

module pfla_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic                         rsp_valid,
   input  wire logic [pfla_pkg::ADDR_W-1:0]  rsp_granted_address,
   input  wire logic [1:0]                   rsp_status
);
   import pfla_pkg::*;

   // A word taken in keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // Each strobe is followed by an idle back end, so strobes never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // Only a successful allocation returns a nonzero address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_granted_address == '0))
      else $error("nonzero address with a failing status");

   // The status code is one of the three defined values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY
                     || rsp_status == STATUS_BAD))
      else $error("undefined status code");

   // Reset leaves the block idle with no response pending.
   assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_granted_address (rsp_granted_address),
   .rsp_status          (rsp_status)
);

`default_nettype wire

// ===== dv/page_free_list_allocator_tb.sv =====
`default_nettype none

module page_free_list_allocator_tb;
   import pfla_pkg::*;

   localparam int PAGE_SHIFT = 12;
   localparam int MAX_PAGES = 1024;
   localparam logic [63:0] PAGE_SIZE = 64'd1 << PAGE_SHIFT;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int ITEMS = 1150;
   localparam int CALM_ITEMS = 150;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        status;
   } grant_type;

   class page_list_checker;
      logic [63:0] region_start;
      logic [63:0] region_stop;
      int unsigned free_top;
      int unsigned next_below [MAX_PAGES];
      grant_type expected_grants [$];
      int unsigned mismatches;
      int unsigned responses;
      int unsigned rebuilds;

      function new();
         region_start = '0;
         region_stop = '0;
         free_top = MAX_PAGES;
         mismatches = 0;
         responses = 0;
         rebuilds = 0;
      endfunction

      function int unsigned pending();
         return expected_grants.size();
      endfunction

      function void write_register(logic idx, logic [ADDR_W-1:0] value);
         if (idx == CSR_REGION_START) begin
            region_start = 64'(value);
         end else begin
            region_stop = 64'(value);
         end
      endfunction

      function void push_page(int unsigned idx);
         next_below[idx] = free_top;
         free_top = idx;
      endfunction

      function void note_request(logic [1:0] mode, logic [ADDR_W-1:0] addr);
         logic [63:0] base;
         logic [63:0] count;
         logic [63:0] pa;
         logic [63:0] idx;
         logic [63:0] total;
         grant_type g;
         base = (region_start + PAGE_SIZE - 64'd1) & ~(PAGE_SIZE - 64'd1);
         pa = 64'(addr);
         g.addr = '0;
         g.status = STATUS_OK;
         case (mode)
            MODE_INIT: begin
               rebuilds++;
               free_top = MAX_PAGES;
               count = '0;
               if (region_stop >= base) count = (region_stop - base) >> PAGE_SHIFT;
               if (count > 64'(MAX_PAGES)) count = 64'(MAX_PAGES);
               for (int i = 0; i < int'(count); i++) push_page(i);
            end
            MODE_ALLOC: begin
               if (free_top < MAX_PAGES) begin
                  total = base + (64'(free_top) << PAGE_SHIFT);
                  g.addr = total[ADDR_W-1:0];
                  free_top = next_below[free_top];
                  if (free_top > MAX_PAGES) free_top = MAX_PAGES;
               end else begin
                  g.status = STATUS_EMPTY;
               end
            end
            MODE_FREE: begin
               if ((pa & (PAGE_SIZE - 64'd1)) != 0 || pa < region_start
                   || pa >= region_stop || pa < base) begin
                  g.status = STATUS_BAD;
               end else begin
                  idx = (pa - base) >> PAGE_SHIFT;
                  if (idx >= 64'(MAX_PAGES)) begin
                     g.status = STATUS_BAD;
                  end else begin
                     push_page(int'(idx));
                  end
               end
            end
            default: begin
            end
         endcase
         expected_grants.push_back(g);
      endfunction

      function void check_response(logic [ADDR_W-1:0] addr, logic [1:0] status);
         grant_type g;
         responses++;
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected response word: address %h status %0d", addr, status);
            end
         end else begin
            g = expected_grants.pop_front();
            if (g.addr !== addr || g.status !== status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("Response mismatch: expected address %h status %0d, got %h status %0d",
                           g.addr, g.status, addr, status);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_mode;
   logic [ADDR_W-1:0] req_page_address;
   logic rsp_valid;
   logic [ADDR_W-1:0] rsp_granted_address;
   logic [1:0] rsp_status;
   logic csr_write_enable;
   logic csr_index;
   logic [ADDR_W-1:0] csr_write_data;

   page_list_checker board = new();
   int unsigned sent = 0;
   int unsigned settings = 0;
   int unsigned large_left = 2;
   int unsigned cycle_count = 0;

   page_free_list_allocator #(
      .PAGE_SHIFT(PAGE_SHIFT),
      .MAX_PAGES(MAX_PAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_page_address(req_page_address),
      .rsp_valid(rsp_valid),
      .rsp_granted_address(rsp_granted_address),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_granted_address, rsp_status);
         if (start && !busy) board.note_request(req_mode, req_page_address);
      end
   end

   function automatic logic [ADDR_W-1:0] rand40();
      logic [ADDR_W-1:0] r;
      r[31:0] = $urandom();
      r[ADDR_W-1:32] = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_word(logic [1:0] mode, logic [ADDR_W-1:0] addr);
      if (sent < ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
         idle_cycles($urandom_range(1, 8));
      end
      start <= 1'b1;
      req_mode <= mode;
      req_page_address <= addr;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [ADDR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      board.write_register(idx, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_region(logic [ADDR_W-1:0] first, logic [ADDR_W-1:0] past);
      wait_idle();
      write_csr(CSR_REGION_START, first);
      write_csr(CSR_REGION_STOP, past);
      settings++;
   endtask

   task automatic random_phase(int n_items);
      logic [63:0] s;
      logic [63:0] e;
      logic [63:0] base;
      logic [63:0] t;
      int pages;
      int kind;
      int pick;
      int sel;
      kind = $urandom_range(0, 19);
      pages = $urandom_range(1, 64);
      s = 64'(rand40() & 40'h7F_FFFF_FFFF);
      if (kind == 0) begin
         e = s >> 1;
      end else if (kind == 1 && large_left > 0) begin
         large_left--;
         pages = $urandom_range(MAX_PAGES + 1, MAX_PAGES + 276);
         s = 64'($urandom_range(0, 4095));
         e = ((s + PAGE_SIZE - 64'd1) & ~(PAGE_SIZE - 64'd1)) + (64'(pages) << PAGE_SHIFT);
      end else if (kind == 2) begin
         e = 64'h00FF_FFFF_FFFF - 64'($urandom_range(0, 4095));
         s = e - (64'(pages) << PAGE_SHIFT) - 64'($urandom_range(0, 4095));
      end else begin
         e = ((s + PAGE_SIZE - 64'd1) & ~(PAGE_SIZE - 64'd1)) + (64'(pages) << PAGE_SHIFT)
             + 64'($urandom_range(0, 4095));
      end
      base = (s + PAGE_SIZE - 64'd1) & ~(PAGE_SIZE - 64'd1);
      set_region(s[ADDR_W-1:0], e[ADDR_W-1:0]);
      send_word(MODE_INIT, rand40());
      repeat (n_items) begin
         if (sent < ITEMS - CALM_ITEMS && $urandom_range(0, 39) == 0) wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_word(MODE_ALLOC, rand40());
         end else if (pick < 88) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) begin
               t = base + (64'($urandom_range(0, pages)) << PAGE_SHIFT);
            end else if (sel < 15) begin
               t = base + (64'($urandom_range(0, pages - 1)) << PAGE_SHIFT)
                   + 64'($urandom_range(1, 4095));
            end else if (sel < 16) begin
               t = (s - 64'($urandom_range(1, 4096))) & ~(PAGE_SIZE - 64'd1);
            end else if (sel < 17) begin
               t = (e + PAGE_SIZE - 64'd1) & ~(PAGE_SIZE - 64'd1);
            end else begin
               t = 64'(rand40());
            end
            send_word(MODE_FREE, t[ADDR_W-1:0]);
         end else if (pick < 94) begin
            send_word(MODE_INIT, rand40());
         end else if (pick < 97) begin
            send_word(MODE_UNUSED, rand40());
         end else begin
            send_word(2'($urandom_range(0, 3)), rand40());
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_INIT;
      req_page_address <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_REGION_START;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the list empty and both registers at zero, nothing can be granted or freed.
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, '0);
      send_word(MODE_UNUSED, '1);

      // Five whole pages after an unaligned start, plus a partial page at the end.
      set_region(40'h00_0000_1001, 40'h00_0000_7800);
      send_word(MODE_INIT, '0);
      send_word(MODE_INIT, '1);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 40'h00_0000_6000);
      send_word(MODE_FREE, 40'h00_0000_6000);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 40'h00_0000_7000);
      send_word(MODE_FREE, 40'h00_0000_6800);
      send_word(MODE_FREE, 40'h00_0000_1000);
      send_word(MODE_FREE, 40'h00_0000_8000);
      send_word(MODE_FREE, '1);

      // More pages than the link store holds.
      set_region('0, 40'h00_0050_0000);
      send_word(MODE_INIT, '0);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 40'h00_0040_0000);
      send_word(MODE_FREE, '0);

      set_region(40'h00_0001_0000, 40'h00_0000_8000);
      send_word(MODE_INIT, '0);
      send_word(MODE_ALLOC, '0);

      // Top of the address space, then a start moved past the list without a rebuild.
      set_region(40'hFF_FFFF_0000, '1);
      send_word(MODE_INIT, '0);
      send_word(MODE_ALLOC, '0);
      wait_idle();
      write_csr(CSR_REGION_START, '1);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_INIT, '0);
      send_word(MODE_ALLOC, '0);

      while (sent < ITEMS) random_phase($urandom_range(30, 60));

      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (10) @(posedge clock);
      $display("Sent %0d request words and checked %0d response words.", sent, board.responses);
      $display("The list was rebuilt %0d times over %0d region settings; %0d mismatches.",
               board.rebuilds, settings, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pfla_pkg.sv
rtl/pfla_front.sv
rtl/pfla_queue.sv
rtl/pfla_back.sv
rtl/page_free_list_allocator.sv
rtl/pfla_checker.sv
dv/page_free_list_allocator_tb.sv
